// ===== hdl/skvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_pkg : shared constants for the sorted key/value table
// command codes, field widths and parameter defaults
// ----------------------------------------------------------------------------
package skvt_pkg;

   localparam int DEFAULT_CAPACITY = 32;
   localparam int DEFAULT_KEY_BITS = 16;

   localparam int KEY_FIELD_BITS   = 16;
   localparam int VALUE_BITS       = 16;
   localparam int CMD_BITS         = 2;
   localparam int COUNT_OUT_BITS   = 6;

   localparam int REQ_DATA_BITS    = 32;
   localparam int RSP_DATA_BITS    = 24;

   localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

endpackage

// ===== hdl/skvt_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_mem : key/value storage
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module skvt_mem #(
   parameter int DEPTH      = skvt_pkg::DEFAULT_CAPACITY,
   parameter int KEY_BITS   = skvt_pkg::DEFAULT_KEY_BITS,
   parameter int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [ADDR_BITS-1:0]            wr_addr,
   input  logic [KEY_BITS-1:0]             wr_key,
   input  logic [skvt_pkg::VALUE_BITS-1:0] wr_value,
   input  logic [ADDR_BITS-1:0]            rd_addr,
   output logic [KEY_BITS-1:0]             rd_key,
   output logic [skvt_pkg::VALUE_BITS-1:0] rd_value
);
   import skvt_pkg::*;

   logic [KEY_BITS-1:0]   key_mem   [DEPTH];
   logic [VALUE_BITS-1:0] value_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         value_mem[wr_addr] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
   end

endmodule

// ===== hdl/sorted_key_value_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_table : sorted key/value table with binary search insert
// lower-bound search over the filled entries, update, ordered insert, clear
// ----------------------------------------------------------------------------
// a clear goes straight to the reply; a lookup runs s search steps (s up to
// ceil(log2(n+1)), n = fill count), then a check unless the key is above
// every entry; inserts shift entries up, all on one ram port and comparator
// throughput: one transaction at a time, not ready until the sequencer is done
// reset: synchronous, clears the fill count, sequencer and output valid;
// ram contents are not cleared and are never read above the fill count
module sorted_key_value_table #(
   parameter int CAPACITY = skvt_pkg::DEFAULT_CAPACITY,
   parameter int KEY_BITS = skvt_pkg::DEFAULT_KEY_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [skvt_pkg::REQ_DATA_BITS-1:0] req_tdata,  // key, value
   input  logic [skvt_pkg::CMD_BITS-1:0]      req_tuser,  // cmd
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [skvt_pkg::RSP_DATA_BITS-1:0] rsp_tdata   // found, read_value,
                                                          // full_res, entry_count
);
   import skvt_pkg::*;

   localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(CAPACITY);
   localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SEARCH  = 3'd1;
   localparam logic [2:0] ST_COMPARE = 3'd2;
   localparam logic [2:0] ST_CHECK   = 3'd3;
   localparam logic [2:0] ST_SHIFT   = 3'd4;
   localparam logic [2:0] ST_MOVE    = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [CNT_BITS-1:0]    lo_ff, lo_in;
   logic [CNT_BITS-1:0]    hi_ff, hi_in;
   logic [CNT_BITS-1:0]    mid_ff, mid_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic [CMD_BITS-1:0]    cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic                   found_ff, found_in;
   logic [VALUE_BITS-1:0]  rv_ff, rv_in;
   logic                   full_ff, full_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                   wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [KEY_BITS-1:0]    wr_key;
   logic [VALUE_BITS-1:0]  wr_value;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [KEY_BITS-1:0]    rd_key;
   logic [VALUE_BITS-1:0]  rd_value;

   logic                   req_fire;
   logic                   rsp_free;

   skvt_mem #(
      .DEPTH     (CAPACITY),
      .KEY_BITS  (KEY_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_value (wr_value),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      logic                miss;
      logic [CNT_BITS-1:0] mid;
      miss         = 1'b0;
      mid          = lo_ff + ((hi_ff - lo_ff) >> 1);
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      found_in     = found_ff;
      rv_in        = rv_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = lo_ff[ADDR_BITS-1:0];
      wr_key       = key_ff;
      wr_value     = value_ff;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_tuser;
               key_in   = KEY_BITS'(req_tdata[KEY_FIELD_BITS-1:0]);
               value_in = req_tdata[KEY_FIELD_BITS +: VALUE_BITS];
               found_in = 1'b0;
               rv_in    = '0;
               full_in  = 1'b0;
               lo_in    = '0;
               hi_in    = count_ff;
               if (req_tuser == CMD_CLEAR) begin
                  count_in = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = mid[ADDR_BITS-1:0];
               mid_in   = mid;
               state_in = ST_COMPARE;
            end else if (lo_ff < count_ff) begin
               rd_addr  = lo_ff[ADDR_BITS-1:0];
               state_in = ST_CHECK;
            end else begin
               miss = 1'b1;
            end
         end
         ST_COMPARE: begin
            if (rd_key < key_ff) begin
               lo_in = mid_ff + CNT_ONE;
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_SEARCH;
         end
         ST_CHECK: begin
            if (rd_key == key_ff) begin
               found_in = 1'b1;
               rv_in    = rd_value;
               wr_en    = (cmd_ff == CMD_ADD);
               state_in = ST_DONE;
            end else begin
               miss = 1'b1;
            end
         end
         ST_SHIFT: begin
            if (idx_ff > lo_ff) begin
               rd_addr  = ADDR_BITS'(idx_ff - CNT_ONE);
               state_in = ST_MOVE;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_ONE;
               state_in = ST_DONE;
            end
         end
         ST_MOVE: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[ADDR_BITS-1:0];
            wr_key   = rd_key;
            wr_value = rd_value;
            idx_in   = idx_ff - CNT_ONE;
            state_in = ST_SHIFT;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {COUNT_OUT_BITS'(count_ff), full_ff, rv_ff, found_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (miss) begin
         if (cmd_ff != CMD_ADD) begin
            state_in = ST_DONE;
         end else if (count_ff >= CNT_FULL) begin
            full_in  = 1'b1;
            state_in = ST_DONE;
         end else begin
            idx_in   = count_ff;
            state_in = ST_SHIFT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      idx_ff      <= idx_in;
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      found_ff    <= found_in;
      rv_ff       <= rv_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hdl/skvt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_checker : port-level checks for the sorted key/value table
// response consistency and handshake behaviour, bound to the top level
// ----------------------------------------------------------------------------
module skvt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [skvt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input logic [skvt_pkg::CMD_BITS-1:0]      req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [skvt_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import skvt_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // refused add never reports a hit
   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[17]))
      else $error("full and found both set");

   // miss returns zero value
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[16:1] == '0)
      else $error("read value nonzero on miss");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind sorted_key_value_table skvt_checker u_skvt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/sorted_key_value_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_table_checker : result checker for the sorted key/value table
// watches both stream channels, keeps its own sorted copy of the table, works
// out the reply to every accepted request and compares each accepted reply
// with the oldest one still awaited, field by field
// ----------------------------------------------------------------------------
module sorted_key_value_table_checker #(
   parameter int CAPACITY = skvt_pkg::DEFAULT_CAPACITY,
   parameter int KEY_BITS = skvt_pkg::DEFAULT_KEY_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [skvt_pkg::REQ_DATA_BITS-1:0] req_tdata,  // key, value
   input  logic [skvt_pkg::CMD_BITS-1:0]      req_tuser,  // cmd
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [skvt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // found, read_value,
                                                          // full_res, entry_count
   output int                                 mismatches,
   output int                                 outstanding
);
   import skvt_pkg::*;

   typedef struct packed {
      logic [COUNT_OUT_BITS-1:0] entry_count;
      logic                      full_res;
      logic [VALUE_BITS-1:0]     read_value;
      logic                      found;
   } reply_type;

   logic [KEY_FIELD_BITS-1:0] table_keys   [CAPACITY];
   logic [VALUE_BITS-1:0]     table_values [CAPACITY];
   int unsigned               table_fill;
   reply_type                 awaited_replies [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      table_fill  = 0;
   end

   function automatic reply_type apply_command(logic [CMD_BITS-1:0]       cmd,
                                               logic [KEY_FIELD_BITS-1:0] key_in,
                                               logic [VALUE_BITS-1:0]     value_in);
      reply_type                 r;
      logic [KEY_FIELD_BITS-1:0] key;
      int unsigned               lo;
      int unsigned               hi;
      int unsigned               mid;
      int unsigned               i;
      r   = '0;
      key = key_in & KEY_FIELD_BITS'((64'd1 << KEY_BITS) - 64'd1);
      if (cmd == CMD_CLEAR) begin
         table_fill = 0;
      end else begin
         // lower bound: first entry whose key is not below the one asked for
         lo = 0;
         hi = table_fill;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (table_keys[mid] < key) lo = mid + 1;
            else hi = mid;
         end
         if (lo < table_fill && table_keys[lo] == key) begin
            r.found      = 1'b1;
            r.read_value = table_values[lo];
            if (cmd == CMD_ADD) table_values[lo] = value_in;
         end else if (cmd == CMD_ADD) begin
            if (table_fill >= CAPACITY) begin
               r.full_res = 1'b1;
            end else begin
               for (i = table_fill; i > lo; i--) begin
                  table_keys[i]   = table_keys[i-1];
                  table_values[i] = table_values[i-1];
               end
               table_keys[lo]   = key;
               table_values[lo] = value_in;
               table_fill++;
            end
         end
      end
      r.entry_count = COUNT_OUT_BITS'(table_fill);
      return r;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      reply_type seen;
      reply_type want;
      if (reset) begin
         table_fill = 0;
         awaited_replies.delete();
      end else begin
         if (req_tvalid && req_tready)
            awaited_replies.push_back(apply_command(req_tuser,
                                                    req_tdata[KEY_FIELD_BITS-1:0],
                                                    req_tdata[KEY_FIELD_BITS +: VALUE_BITS]));
         if (rsp_tvalid && rsp_tready) begin
            seen = reply_type'(rsp_tdata);
            if (awaited_replies.size() == 0) begin
               report_mismatch("result transaction with nothing awaited", seen, 0);
            end else begin
               want = awaited_replies.pop_front();
               if (seen.found !== want.found)
                  report_mismatch("found", seen.found, want.found);
               if (seen.read_value !== want.read_value)
                  report_mismatch("read_value", seen.read_value, want.read_value);
               if (seen.full_res !== want.full_res)
                  report_mismatch("full_res", seen.full_res, want.full_res);
               if (seen.entry_count !== want.entry_count)
                  report_mismatch("entry_count", seen.entry_count, want.entry_count);
            end
         end
      end
      outstanding <= awaited_replies.size();
   end

endmodule

// ===== dv/sorted_key_value_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_table_test : top level of the sorted key/value table bench
// directed lookups, inserts, updates and clears, then random episodes that
// each start from an empty table and draw keys from a small pool so that
// hits, ordered inserts and the full table all come up; both channels idle
// at random and the result side holds off for long stretches twice
// ----------------------------------------------------------------------------
module sorted_key_value_table_test;
   import skvt_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 1600;
   localparam int KEY_POOL     = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 120;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;  // key, value
   logic [CMD_BITS-1:0]      req_tuser  = '0;  // cmd
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // found, read_value, full_res, entry_count
   int                       mismatches;
   int                       outstanding;
   bit                       calm = 1'b0;
   logic [KEY_FIELD_BITS-1:0] key_pool [KEY_POOL];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sorted_key_value_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sorted_key_value_table_checker table_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send(logic [CMD_BITS-1:0] cmd, logic [KEY_FIELD_BITS-1:0] key,
                       logic [VALUE_BITS-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {value, key};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // result side: random stalls, long hold-offs on two occasions
   initial begin
      int rounds;
      int gap;
      rounds = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rounds == 30 || rounds == 600) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rounds++;
      end
   end

   initial begin
      #15_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int                        sent;
      int                        episode;
      int                        span;
      int                        add_share;
      int                        r;
      int                        i;
      logic [KEY_FIELD_BITS-1:0] key;
      logic [KEY_FIELD_BITS-1:0] base;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table, inserts at both ends and in the middle
      send(CMD_LOOKUP, 16'h0000, 16'h0000);
      send(CMD_ADD,    16'h0000, 16'hffff);
      send(CMD_ADD,    16'hffff, 16'h0001);
      send(CMD_ADD,    16'h8000, 16'haaaa);
      send(CMD_ADD,    16'h0001, 16'h5555);
      send(CMD_LOOKUP, 16'h0000, 16'h1234);
      send(CMD_LOOKUP, 16'hffff, 16'h0000);
      send(CMD_LOOKUP, 16'h7fff, 16'hffff);
      // update of a present key
      send(CMD_ADD,    16'h8000, 16'h1234);
      send(CMD_LOOKUP, 16'h8000, 16'hffff);
      // spare code behaves as a lookup
      send(CMD_SPARE,  16'h8000, 16'h0000);
      send(CMD_SPARE,  16'h0002, 16'hffff);
      send(CMD_CLEAR,  16'hffff, 16'hffff);
      send(CMD_LOOKUP, 16'h0000, 16'h0000);
      send(CMD_CLEAR,  16'h0000, 16'h0000);
      send(CMD_ADD,    16'h5a5a, 16'ha5a5);

      sent    = 0;
      episode = 0;
      while (sent < RANDOM_ITEMS) begin
         if (episode == 0 || $urandom_range(0, 1) == 1) wait_drained();
         calm = (episode != 0) && ($urandom_range(0, 3) == 0);
         base = KEY_FIELD_BITS'($urandom);
         for (i = 0; i < KEY_POOL; i++) begin
            r = $urandom_range(0, 9);
            case (r)
               0: begin
                  key_pool[i] = '0;
               end
               1: begin
                  key_pool[i] = '1;
               end
               2, 3, 4: begin
                  key_pool[i] = base + KEY_FIELD_BITS'($urandom_range(0, 63));
               end
               default: begin
                  key_pool[i] = KEY_FIELD_BITS'($urandom);
               end
            endcase
         end
         // first episode tries to fill the table past capacity
         add_share = (episode == 0) ? 90 : $urandom_range(30, 90);
         span      = (episode == 0) ? 60 : $urandom_range(20, 120);
         send(CMD_CLEAR, KEY_FIELD_BITS'($urandom), VALUE_BITS'($urandom));
         sent++;
         repeat (span) begin
            r   = $urandom_range(0, 99);
            key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            if (r < 2)
               send(CMD_CLEAR, key, VALUE_BITS'($urandom));
            else if (r < 5)
               send(CMD_SPARE, key, VALUE_BITS'($urandom));
            else if (r < 10)
               send(($urandom_range(0, 1) == 1) ? CMD_ADD : CMD_LOOKUP,
                    KEY_FIELD_BITS'($urandom), VALUE_BITS'($urandom));
            else if ($urandom_range(0, 99) < add_share)
               send(CMD_ADD, key, VALUE_BITS'($urandom));
            else
               send(CMD_LOOKUP, key, VALUE_BITS'($urandom));
            sent++;
         end
         episode++;
      end

      calm = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/skvt_pkg.sv
hdl/skvt_mem.sv
hdl/sorted_key_value_table.sv
hdl/skvt_checker.sv
dv/sorted_key_value_table_checker.sv
dv/sorted_key_value_table_test.sv
